### sv/basca_pkg.sv
// ----------------------------------------------------------------------------
// basca_pkg: shared types and codes for the bump and size-class allocator
// Request and response payload layouts, function codes, status codes,
// register addresses and the controller state encoding.
// ----------------------------------------------------------------------------
package basca_pkg;

   // Function codes carried in a request
   localparam logic [1:0] FUNC_ALLOC    = 2'd0;
   localparam logic [1:0] FUNC_RELEASE  = 2'd1;
   localparam logic [1:0] FUNC_RESET    = 2'd2;
   localparam logic [1:0] FUNC_ROLLBACK = 2'd3;

   // Status codes carried in a response
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_FULL     = 2'd1;
   localparam logic [1:0] STATUS_DISABLED = 2'd2;
   localparam logic [1:0] STATUS_BAD_MARK = 2'd3;

   // Register index of arena_enable (byte address 4*index)
   localparam logic CSR_IDX_ENABLE = 1'b0;

   // Heap granule in bytes, as a shift
   localparam int WORD_SHIFT = 3;

   typedef struct packed {
      logic [1:0]  func;
      logic [19:0] req_size;
      logic [18:0] block_addr;
      logic [19:0] rollback_mark;
   } basca_req_type;

   typedef struct packed {
      logic [18:0] result_addr;
      logic [1:0]  status;
      logic        from_free_list;
      logic [19:0] bump_level;
      logic [19:0] bytes_in_use;
   } basca_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_LOOK = 4'b0010,
      ST_POP  = 4'b0100,
      ST_FIN  = 4'b1000
   } basca_state_type;

endpackage

### sv/basca_ram.sv
// ----------------------------------------------------------------------------
// basca_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered and holds
// until the next read.
// ----------------------------------------------------------------------------
module basca_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write, then registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/bump_and_size_class_allocator.sv
// ----------------------------------------------------------------------------
// bump_and_size_class_allocator: segregated free-list plus bump allocator
// Serves allocate, release, heap reset and rollback requests over one heap
// region in 8-byte words. List heads and per-word links live in RAM.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake               Payload
//  req_      in         req_valid / req_stall    basca_req_type
//  rsp_      out        rsp_valid / rsp_stall    basca_rsp_type
//  csr_      in/out     APB psel/penable/pready  arena_enable at address 0
//
//  A request passes through accept, head lookup and finish; an allocation
//  served from a free list adds a pop step, the dependent read of the link
//  RAM after the head RAM read.
//  Reset is synchronous and active high; it empties every free list at once
//  through per-class valid flops, so no clearing pass is needed.
//  A finished response waits in the output register; the next request is
//  accepted meanwhile and only its finish step waits on rsp_stall.
//
module bump_and_size_class_allocator
   import basca_pkg::*;
#(
   parameter int HEAP_WORDS   = 65536,
   parameter int SIZE_CLASSES = 128
) (
   input  logic          clock,
   input  logic          reset,
   // request channel
   input  logic          req_valid,
   output logic          req_stall,
   input  basca_req_type req_data,
   // response channel
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output basca_rsp_type rsp_data,
   // configuration port
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [2:0]    csr_paddr,
   input  logic [31:0]   csr_pwdata,
   output logic [31:0]   csr_prdata,
   output logic          csr_pready
);

   localparam int HEAP_BYTES = HEAP_WORDS * 8;
   localparam int BYTES_W    = $clog2(HEAP_BYTES + 1);
   localparam int PTR_W      = (BYTES_W > 21) ? BYTES_W : 21;
   localparam int IDX_W      = $clog2(HEAP_WORDS);
   localparam int CLS_W      = $clog2(SIZE_CLASSES);
   localparam int LINK_W     = IDX_W + 1;

   // Control and state registers
   basca_state_type         state_ff, state_in;
   logic                    enable_ff, enable_in;
   logic [PTR_W-1:0]        bump_ff, bump_in;
   logic [PTR_W-1:0]        total_ff, total_in;
   logic [SIZE_CLASSES-1:0] list_valid_ff, list_valid_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   basca_rsp_type           rsp_data_ff, rsp_data_in;

   // Request context held across the steps
   logic [1:0]              func_ff;
   logic [20:0]             size_ff;
   logic [CLS_W-1:0]        cls_ff;
   logic                    cls_ok_ff;
   logic [IDX_W-1:0]        idx_ff;
   logic                    idx_ok_ff;
   logic [19:0]             mark_ff;
   logic                    hit_ff;
   logic [PTR_W-1:0]        room_ff;
   logic [PTR_W-1:0]        drop_ff;
   logic                    mark_hi_ff;

   // Accept-side decode
   logic                    req_accept;
   logic [19:0]             size_nz;
   logic [20:0]             size_rnd;
   logic [17:0]             alloc_cls;
   logic [16:0]             rel_cls;
   logic [15:0]             blk_idx;
   logic                    sel_cls_ok;
   logic [CLS_W-1:0]        sel_cls;

   // Lookup and finish
   logic                    pop_hit;
   logic                    fin_fire;
   logic [PTR_W-1:0]        mark_ext;
   logic [PTR_W-1:0]        size_ext;

   // RAM ports
   logic                    head_wr_en;
   logic [IDX_W-1:0]        head_wr_data;
   logic                    head_rd_en;
   logic [IDX_W-1:0]        head_rd_data;
   logic                    link_wr_en;
   logic [LINK_W-1:0]       link_wr_data;
   logic                    link_rd_en;
   logic [LINK_W-1:0]       link_rd_data;

   // Configuration port: one register, written in the access phase
   logic                    csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_ENABLE) ? {31'd0, enable_ff} : 32'd0;

   always_comb begin
      enable_in = enable_ff;
      if (csr_write && (csr_paddr[2] == CSR_IDX_ENABLE)) begin
         enable_in = csr_pwdata[0];
      end
   end

   // Decode the incoming request: round the allocation size, pick the class
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign size_nz    = (req_data.req_size == 20'd0) ? 20'd8 : req_data.req_size;
   assign size_rnd   = (21'(size_nz) + 21'd7) & ~21'd7;
   assign alloc_cls  = size_rnd[20:WORD_SHIFT];
   assign rel_cls    = req_data.req_size[19:WORD_SHIFT];
   assign blk_idx    = req_data.block_addr[18:WORD_SHIFT];

   always_comb begin
      if (req_data.func == FUNC_ALLOC) begin
         sel_cls_ok = (32'(alloc_cls) < 32'(SIZE_CLASSES));
         sel_cls    = CLS_W'(alloc_cls);
      end else begin
         sel_cls_ok = (32'(rel_cls) < 32'(SIZE_CLASSES));
         sel_cls    = CLS_W'(rel_cls);
      end
   end

   // Pop on an allocation when the class is in range, the arena is enabled and its list is not empty
   assign pop_hit = (func_ff == FUNC_ALLOC) && enable_ff && cls_ok_ff
                    && list_valid_ff[cls_ff];

   assign head_rd_en = req_accept;
   assign link_rd_en = (state_ff == ST_LOOK) && pop_hit;

   // Advance the sequencer
   assign fin_fire = (state_ff == ST_FIN) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            state_in = pop_hit ? ST_POP : ST_FIN;
         end
         ST_POP: begin
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (fin_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Finish step: build the response and the state and RAM updates
   assign mark_ext = PTR_W'(mark_ff);
   assign size_ext = PTR_W'(size_ff);

   always_comb begin
      bump_in       = bump_ff;
      total_in      = total_ff;
      list_valid_in = list_valid_ff;
      head_wr_en    = 1'b0;
      head_wr_data  = idx_ff;
      link_wr_en    = 1'b0;
      link_wr_data  = {list_valid_ff[cls_ff], head_rd_data};
      rsp_data_in   = '0;
      rsp_data_in.status = STATUS_OK;
      case (func_ff)
         FUNC_ALLOC: begin
            if (!enable_ff) begin
               rsp_data_in.status = STATUS_DISABLED;
            end else if (hit_ff) begin
               rsp_data_in.result_addr    = 19'({head_rd_data, 3'b000});
               rsp_data_in.from_free_list = 1'b1;
               head_wr_en                 = 1'b1;
               head_wr_data               = link_rd_data[IDX_W-1:0];
               list_valid_in[cls_ff]      = link_rd_data[IDX_W];
            end else if (size_ext > room_ff) begin
               rsp_data_in.status = STATUS_FULL;
            end else begin
               rsp_data_in.result_addr = 19'(bump_ff);
               bump_in                 = bump_ff + size_ext;
               total_in                = total_ff + size_ext;
            end
         end
         FUNC_RELEASE: begin
            if (cls_ok_ff && idx_ok_ff) begin
               link_wr_en            = 1'b1;
               head_wr_en            = 1'b1;
               list_valid_in[cls_ff] = 1'b1;
            end
         end
         FUNC_RESET: begin
            bump_in       = '0;
            total_in      = '0;
            list_valid_in = '0;
         end
         FUNC_ROLLBACK: begin
            if (mark_hi_ff) begin
               rsp_data_in.status = STATUS_BAD_MARK;
            end else begin
               bump_in  = mark_ext;
               total_in = (drop_ff > total_ff) ? '0 : (total_ff - drop_ff);
            end
         end
         default: begin
            rsp_data_in.status = STATUS_OK;
         end
      endcase
      rsp_data_in.bump_level   = bump_in[19:0];
      rsp_data_in.bytes_in_use = total_in[19:0];
   end

   // Hold the response until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fin_fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         enable_ff     <= 1'b1;
         bump_ff       <= '0;
         total_ff      <= '0;
         list_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         enable_ff    <= enable_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fin_fire) begin
            bump_ff       <= bump_in;
            total_ff      <= total_in;
            list_valid_ff <= list_valid_in;
         end
      end
   end

   // Payload and context registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         func_ff   <= req_data.func;
         size_ff   <= size_rnd;
         cls_ff    <= sel_cls;
         cls_ok_ff <= sel_cls_ok;
         idx_ff    <= IDX_W'(blk_idx);
         idx_ok_ff <= (32'(blk_idx) < 32'(HEAP_WORDS));
         mark_ff   <= req_data.rollback_mark;
      end
      if (state_ff == ST_LOOK) begin
         hit_ff     <= pop_hit;
         room_ff    <= PTR_W'(HEAP_BYTES) - bump_ff;
         drop_ff    <= bump_ff - mark_ext;
         mark_hi_ff <= (mark_ext > bump_ff);
      end
      if (fin_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // List heads: one word index per size class
   basca_ram #(
      .WIDTH (IDX_W),
      .DEPTH (SIZE_CLASSES)
   ) u_head_ram (
      .clock   (clock),
      .wr_en   (head_wr_en && fin_fire),
      .wr_addr (cls_ff),
      .wr_data (head_wr_data),
      .rd_en   (head_rd_en),
      .rd_addr (sel_cls),
      .rd_data (head_rd_data)
   );

   // Links: valid bit plus next word index, one per heap word
   basca_ram #(
      .WIDTH (LINK_W),
      .DEPTH (HEAP_WORDS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_wr_en && fin_fire),
      .wr_addr (idx_ff),
      .wr_data (link_wr_data),
      .rd_en   (link_rd_en),
      .rd_addr (head_rd_data),
      .rd_data (link_rd_data)
   );

   // A response appears only out of the finish step
   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FIN))
      else $error("response raised without a finish step");

   // Bytes handed out never exceed the bump level
   a_total_le_bump: assert property (@(posedge clock) disable iff (reset)
      total_ff <= bump_ff)
      else $error("bytes in use above bump level");

   // The bump level stays inside the heap
   a_bump_in_heap: assert property (@(posedge clock) disable iff (reset)
      bump_ff <= PTR_W'(HEAP_BYTES))
      else $error("bump pointer beyond heap");

   // An accepted request goes straight to the head lookup
   a_accept_to_look: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_LOOK))
      else $error("accepted request did not start lookup");

endmodule

### test/bump_and_size_class_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bump_and_size_class_allocator_tb: self-checking bench for the heap allocator
// Runs a short directed table of allocate, release, heap reset and rollback
// requests, then random traffic in phases of sender idling, receiver
// stalling and arena enable settings. A bit-accurate heap model in the bench
// predicts each response not typed in the table; DUT responses are compared by field.
// ----------------------------------------------------------------------------
module bump_and_size_class_allocator_tb;
   import basca_pkg::*;

   localparam int          HEAP_WORDS     = 65536;
   localparam int          SIZE_CLASSES   = 128;
   localparam int unsigned HEAP_BYTES     = HEAP_WORDS << WORD_SHIFT;
   localparam int unsigned MAX_BLOCK_ADDR = HEAP_BYTES - 8;
   localparam int          RANDOM_PHASES  = 8;
   localparam int          PHASE_REQUESTS = 240;
   localparam int          HOLD_CYCLES    = 300;
   localparam int          MAX_PRINTS     = 50;
   localparam logic [2:0]  ENABLE_ADDR    = {CSR_IDX_ENABLE, 2'b00};

   typedef struct packed {
      basca_req_type item;
      logic          enable;
      logic          typed;
      basca_rsp_type want;
   } stim_row_type;

   logic          clock       = 1'b0;
   logic          reset       = 1'b1;
   logic          req_valid   = 1'b0;
   logic          req_stall;
   basca_req_type req_data    = '0;
   logic          rsp_valid;
   logic          rsp_stall   = 1'b0;
   basca_rsp_type rsp_data;
   logic          csr_psel    = 1'b0;
   logic          csr_penable = 1'b0;
   logic          csr_pwrite  = 1'b0;
   logic [2:0]    csr_paddr   = '0;
   logic [31:0]   csr_pwdata  = '0;
   logic [31:0]   csr_prdata;
   logic          csr_pready;

   // heap model: configuration, bump state and free lists
   logic          arena_on;
   int unsigned   heap_bump;
   int unsigned   heap_used;
   logic [16:0]   class_head [SIZE_CLASSES];
   logic [16:0]   word_link  [HEAP_WORDS];

   basca_rsp_type heap_replies_due [$];
   stim_row_type  directed_rows [$];
   int unsigned   live_addr [$];
   int unsigned   live_size [$];
   int unsigned   bump_marks [$];

   int            send_idle_pct  = 0;
   int            recv_stall_pct = 0;
   int            hold_left      = 0;
   int            mismatch_count = 0;
   int            reply_count    = 0;

   bump_and_size_class_allocator #(
      .HEAP_WORDS   (HEAP_WORDS),
      .SIZE_CLASSES (SIZE_CLASSES)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic report_error(input string msg);
      if (mismatch_count < MAX_PRINTS) $display("ERROR: %s", msg);
      mismatch_count++;
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want)
         report_error($sformatf("response %0d %s: got %0d, want %0d",
                                reply_count, name, got, want));
   endtask

   // Round a request size up to whole 8-byte words, zero counting as one word
   function automatic int unsigned granule_size(input logic [19:0] req);
      int unsigned size;
      size = (req == 0) ? 8 : 32'(req);
      return (size + 7) & 32'hFFFF_FFF8;
   endfunction

   function automatic void clear_heap_model();
      heap_bump = 0;
      heap_used = 0;
      foreach (class_head[c]) class_head[c] = '0;
   endfunction

   // Advance the heap model by one request and return its response
   function automatic basca_rsp_type heap_step(input basca_req_type item);
      basca_rsp_type reply;
      int unsigned   size;
      int unsigned   cls;
      int unsigned   word;
      int unsigned   drop;
      reply = '0;
      case (item.func)
         FUNC_ALLOC: begin
            size = granule_size(item.req_size);
            cls  = size >> WORD_SHIFT;
            if (!arena_on) begin
               reply.status = STATUS_DISABLED;
            end else if (cls < SIZE_CLASSES && class_head[cls][16]) begin
               // pop the head of the class list
               word = 32'(class_head[cls][15:0]);
               class_head[cls]      = word_link[word];
               reply.result_addr    = 19'(word << WORD_SHIFT);
               reply.from_free_list = 1'b1;
            end else if (size > HEAP_BYTES - heap_bump) begin
               reply.status = STATUS_FULL;
            end else begin
               reply.result_addr = heap_bump[18:0];
               heap_bump = heap_bump + size;
               heap_used = heap_used + size;
            end
         end
         FUNC_RELEASE: begin
            // push onto the class list, drop oversize classes
            cls  = 32'(item.req_size >> WORD_SHIFT);
            word = 32'(item.block_addr >> WORD_SHIFT);
            if (cls < SIZE_CLASSES && word < HEAP_WORDS) begin
               word_link[word] = class_head[cls];
               class_head[cls] = {1'b1, word[15:0]};
            end
         end
         FUNC_RESET: begin
            clear_heap_model();
         end
         default: begin
            if (32'(item.rollback_mark) > heap_bump) begin
               reply.status = STATUS_BAD_MARK;
            end else begin
               drop      = heap_bump - 32'(item.rollback_mark);
               heap_used = (drop > heap_used) ? 0 : heap_used - drop;
               heap_bump = 32'(item.rollback_mark);
            end
         end
      endcase
      reply.bump_level   = heap_bump[19:0];
      reply.bytes_in_use = heap_used[19:0];
      return reply;
   endfunction

   function automatic void add_row(input logic [1:0] func, input int unsigned size,
                                   input int unsigned addr, input int unsigned mark,
                                   input logic enable, input logic typed,
                                   input int unsigned want_addr,
                                   input logic [1:0] want_status, input logic want_ffl,
                                   input int unsigned want_bump,
                                   input int unsigned want_used);
      stim_row_type row;
      row.item.func                = func;
      row.item.req_size            = size[19:0];
      row.item.block_addr          = addr[18:0];
      row.item.rollback_mark       = mark[19:0];
      row.enable                   = enable;
      row.typed                    = typed;
      row.want.result_addr         = want_addr[18:0];
      row.want.status              = want_status;
      row.want.from_free_list      = want_ffl;
      row.want.bump_level          = want_bump[19:0];
      row.want.bytes_in_use        = want_used[19:0];
      directed_rows.push_back(row);
   endfunction

   // Offer one request after a random idle gap and hold it until taken
   task automatic send_request(input basca_req_type item);
      int gap;
      gap = 0;
      while (gap < 20 && $urandom_range(0, 99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Stop offering and wait until every due response has arrived
   task automatic drain_replies();
      req_valid <= 1'b0;
      @(posedge clock);
      while (heap_replies_due.size() != 0) @(posedge clock);
   endtask

   // Write arena_enable, then read it back
   task automatic write_enable(input logic value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ENABLE_ADDR;
      csr_pwdata  <= {31'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      arena_on = value;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata[0] !== value)
         report_error($sformatf("arena_enable read back %0b, want %0b",
                                csr_prdata[0], value));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Take responses, check them in order, and drive the stall
   always @(posedge clock) begin : take_reply
      basca_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (heap_replies_due.size() == 0) begin
               report_error($sformatf("response %0d arrived with none due", reply_count));
            end else begin
               want = heap_replies_due.pop_front();
               compare_field("result_addr", 32'(rsp_data.result_addr),
                             32'(want.result_addr));
               compare_field("status", 32'(rsp_data.status), 32'(want.status));
               compare_field("from_free_list", 32'(rsp_data.from_free_list),
                             32'(want.from_free_list));
               compare_field("bump_level", 32'(rsp_data.bump_level),
                             32'(want.bump_level));
               compare_field("bytes_in_use", 32'(rsp_data.bytes_in_use),
                             32'(want.bytes_in_use));
            end
            reply_count++;
         end
         // hold off for a requested stretch, else stall at random
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
         end
      end
   end

   initial begin
      basca_req_type item;
      basca_rsp_type reply;
      stim_row_type  row;
      int            pick;
      int            k;
      int            mode;

      arena_on = 1'b1;
      clear_heap_model();

      // func, size, addr, mark, enable, typed, then addr, status, ffl, bump, used
      add_row(FUNC_ALLOC,    0,      0,      0,      1, 1, 0,  STATUS_OK,   0, 8,  8);
      add_row(FUNC_ALLOC,    1,      0,      0,      1, 1, 8,  STATUS_OK,   0, 16, 16);
      add_row(FUNC_ALLOC,    13,     0,      0,      1, 1, 16, STATUS_OK,   0, 32, 32);
      add_row(FUNC_RELEASE,  8,      8,      0,      1, 1, 0,  STATUS_OK,   0, 32, 32);
      add_row(FUNC_ALLOC,    5,      0,      0,      1, 1, 8,  STATUS_OK,   1, 32, 32);
      // release below one word lands in a class nothing pops
      add_row(FUNC_RELEASE,  3,      524279, 0,      1, 1, 0,  STATUS_OK,   0, 32, 32);
      add_row(FUNC_ALLOC,    0,      0,      0,      1, 1, 32, STATUS_OK,   0, 40, 40);
      // top size class: push then pop
      add_row(FUNC_RELEASE,  1016,   40,     0,      1, 0, 0,  STATUS_OK,   0, 0,  0);
      add_row(FUNC_ALLOC,    1016,   0,      0,      1, 0, 0,  STATUS_OK,   0, 0,  0);
      // oversize class: release dropped, allocation bumps
      add_row(FUNC_RELEASE,  1024,   0,      0,      1, 0, 0,  STATUS_OK,   0, 0,  0);
      add_row(FUNC_ALLOC,    1024,   0,      0,      1, 0, 0,  STATUS_OK,   0, 0,  0);
      add_row(FUNC_ROLLBACK, 0,      0,      524288, 1, 1, 0,  STATUS_BAD_MARK, 0, 1064, 1064);
      add_row(FUNC_RELEASE,  16,     64,     0,      1, 0, 0,  STATUS_OK,   0, 0,  0);
      add_row(FUNC_ROLLBACK, 0,      0,      16,     1, 0, 0,  STATUS_OK,   0, 0,  0);
      add_row(FUNC_ALLOC,    524288, 0,      0,      1, 1, 0,  STATUS_FULL, 0, 16, 16);
      // heap reset must also empty the class lists
      add_row(FUNC_RESET,    0,      0,      0,      1, 1, 0,  STATUS_OK,   0, 0,  0);
      add_row(FUNC_ALLOC,    16,     0,      0,      1, 1, 0,  STATUS_OK,   0, 16, 16);
      add_row(FUNC_ROLLBACK, 0,      0,      0,      1, 1, 0,  STATUS_OK,   0, 0,  0);
      add_row(FUNC_ALLOC,    524288, 0,      0,      1, 1, 0,  STATUS_OK,   0, 524288, 524288);
      add_row(FUNC_ALLOC,    0,      0,      0,      1, 1, 0,  STATUS_FULL, 0, 524288, 524288);
      add_row(FUNC_ROLLBACK, 0,      0,      524288, 1, 1, 0,  STATUS_OK,   0, 524288, 524288);
      add_row(FUNC_RELEASE,  0,      0,      0,      1, 0, 0,  STATUS_OK,   0, 0,  0);
      add_row(FUNC_ALLOC,    0,      0,      0,      0, 1, 0,  STATUS_DISABLED, 0, 524288, 524288);
      add_row(FUNC_ROLLBACK, 0,      0,      8,      0, 0, 0,  STATUS_OK,   0, 0,  0);
      add_row(FUNC_ALLOC,    524281, 0,      0,      1, 0, 0,  STATUS_OK,   0, 0,  0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_enable(1'b1);

      // walk the directed table
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.enable !== arena_on) begin
            drain_replies();
            write_enable(row.enable);
         end
         send_request(row.item);
         reply = heap_step(row.item);
         heap_replies_due.push_back(row.typed ? row.want : reply);
      end

      // random phases: idling and stalling pattern by phase, arena disabled in two of them
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         mode = phase % 4;
         send_idle_pct  = (mode == 1) ? 50 : (mode == 3) ? 8 : 0;
         recv_stall_pct = (mode == 2) ? 50 : (mode == 3) ? 8 : 0;
         drain_replies();
         write_enable(!(phase == 2 || phase == 6));

         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            // long receiver hold while requests keep coming
            if (n == 60 && mode == 0) hold_left = HOLD_CYCLES;
            // pause the sender until the pipe is empty
            if (n == 120) drain_replies();

            item.func          = FUNC_ALLOC;
            item.req_size      = 20'($urandom_range(0, 128));
            item.block_addr    = 19'($urandom_range(0, MAX_BLOCK_ADDR));
            item.rollback_mark = 20'($urandom_range(0, HEAP_BYTES));
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
               // allocate, mostly small classes that recycle
               k = $urandom_range(0, 19);
               if (k >= 18) item.req_size = 20'($urandom_range(0, HEAP_BYTES));
               else if (k >= 14) item.req_size = 20'($urandom_range(0, 1100));
            end else if (pick < 70) begin
               // release a live block into its own class
               item.func     = FUNC_RELEASE;
               item.req_size = 20'($urandom_range(0, 1100));
               if (live_addr.size() > 0) begin
                  k = $urandom_range(0, live_addr.size() - 1);
                  item.req_size   = 20'(live_size[k] + $urandom_range(0, 7));
                  item.block_addr = 19'(live_addr[k]);
                  if (live_addr[k] < MAX_BLOCK_ADDR)
                     item.block_addr = 19'(live_addr[k] + $urandom_range(0, 7));
                  live_addr.delete(k);
                  live_size.delete(k);
               end
            end else if (pick < 85) begin
               // roll back to an earlier level, a fresh one, or anywhere
               item.func = FUNC_ROLLBACK;
               k = $urandom_range(0, 3);
               if (k < 2 && bump_marks.size() > 0)
                  item.rollback_mark =
                     20'(bump_marks[$urandom_range(0, bump_marks.size() - 1)]);
               else if (k == 2)
                  item.rollback_mark = 20'($urandom_range(0, heap_bump));
            end else if (pick < 88) begin
               item.func = FUNC_RESET;
            end else begin
               // noise
               item.func     = 2'($urandom_range(0, 3));
               item.req_size = 20'($urandom_range(0, HEAP_BYTES));
            end

            send_request(item);
            reply = heap_step(item);
            heap_replies_due.push_back(reply);

            // track live blocks and checkpoints for later requests
            if (item.func == FUNC_RESET) begin
               live_addr.delete();
               live_size.delete();
               bump_marks.delete();
            end else if (item.func == FUNC_ALLOC && reply.status == STATUS_OK) begin
               live_addr.push_back(32'(reply.result_addr));
               live_size.push_back(granule_size(item.req_size));
               if (live_addr.size() > 128) begin
                  live_addr.pop_front();
                  live_size.pop_front();
               end
            end
            if (bump_marks.size() < 32) bump_marks.push_back(32'(reply.bump_level));
            else bump_marks[$urandom_range(0, 31)] = 32'(reply.bump_level);
         end
      end

      drain_replies();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("bump_and_size_class_allocator verification clean");
      end else begin
         $display("bump_and_size_class_allocator verification failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #4_000_000;
      $display("bump_and_size_class_allocator verification failed");
      $finish;
   end

endmodule

### files.f
sv/basca_pkg.sv
sv/basca_ram.sv
sv/bump_and_size_class_allocator.sv
test/bump_and_size_class_allocator_tb.sv
